// ===== rtl/core/swipe_gesture_detector_unit_assert.svh =====
// Assertion macros shared by the swipe detector RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef SWIPE_GESTURE_DETECTOR_UNIT_ASSERT_SVH
`define SWIPE_GESTURE_DETECTOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clock edge outside reset.
`define SWD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that implies another one in the next cycle.
`define SWD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SWD_ASSERT(lbl, prop, msg)
`define SWD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/swd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swd_pkg;

	localparam int CFG_W = 16;

	// Touch event kinds.
	localparam logic [1:0] FUNC_BEGAN  = 2'd0;
	localparam logic [1:0] FUNC_MOVED  = 2'd1;
	localparam logic [1:0] FUNC_ENDED  = 2'd2;
	localparam logic [1:0] FUNC_CANCEL = 2'd3;

	// Reported gesture events.
	localparam logic [1:0] EV_BEGIN   = 2'd0;
	localparam logic [1:0] EV_MOVED   = 2'd1;
	localparam logic [1:0] EV_FAILED  = 2'd2;
	localparam logic [1:0] EV_SUCCESS = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_ALLOW_H  = 2'd0;
	localparam logic [1:0] REG_ALLOW_V  = 2'd1;
	localparam logic [1:0] REG_MIN_MOVE = 2'd2;
	localparam logic [1:0] REG_MIN_VEL  = 2'd3;

	localparam logic [15:0] MIN_MOVE_RST = 16'd160;
	localparam logic [15:0] MIN_VEL_RST  = 16'd256;

	typedef struct packed {
		logic        allow_h;
		logic        allow_v;
		logic [15:0] min_move;
		logic [15:0] min_vel;
	} swd_cfg_t;

	// One word handed from the tracker to the judge stage.
	typedef struct packed {
		logic [1:0]         ev;
		logic               has_result;
		logic               judge;
		logic               ovx;
		logic               ovy;
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic [31:0]        dt;
	} swd_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/swd_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swd_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [swd_pkg::CFG_W-1:0]    cfg_data,
	output swd_pkg::swd_cfg_t            cfg
);
	import swd_pkg::*;

	swd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.allow_h  <= 1'b1;
			cfg_q.allow_v  <= 1'b1;
			cfg_q.min_move <= MIN_MOVE_RST;
			cfg_q.min_vel  <= MIN_VEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALLOW_H: begin
					cfg_q.allow_h <= cfg_data[0];
				end
				REG_ALLOW_V: begin
					cfg_q.allow_v <= cfg_data[0];
				end
				REG_MIN_MOVE: begin
					cfg_q.min_move <= cfg_data[15:0];
				end
				REG_MIN_VEL: begin
					cfg_q.min_vel <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/swd_track.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "swipe_gesture_detector_unit_assert.svh"

module swd_track (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	input  logic                 touch_valid,
	input  logic signed [15:0]   pos_x,
	input  logic signed [15:0]   pos_y,
	input  logic [31:0]          time_ms,
	input  swd_pkg::swd_cfg_t    cfg,
	input  logic                 item_ready,
	output logic                 item_valid,
	output swd_pkg::swd_item_t   item
);
	import swd_pkg::*;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_BEGUN  = 2'd1;
	localparam logic [1:0] PH_MOVING = 2'd2;

	logic        v_s1;
	logic [1:0]  func_s1;
	logic        touch_valid_s1;
	logic [15:0] pos_x_s1;
	logic [15:0] pos_y_s1;
	logic [31:0] time_s1;

	logic [1:0]  phase_q;
	logic [15:0] start_x_q;
	logic [15:0] start_y_q;
	logic [31:0] start_time_q;

	logic        v_s2;
	swd_item_t   item_s2;

	logic        s1_adv;
	logic        s1_fire;
	logic [16:0] dx;
	logic [16:0] dy;
	logic [16:0] adx;
	logic [16:0] ady;
	logic        ovx;
	logic        ovy;
	logic [1:0]  phase_d;
	logic        load;
	logic        go_idle;
	swd_item_t   item_d;

	assign s1_adv   = !v_s2 || item_ready;
	assign s1_fire  = v_s1 && s1_adv;
	assign in_ready = !v_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1        <= func;
			touch_valid_s1 <= touch_valid;
			pos_x_s1       <= pos_x;
			pos_y_s1       <= pos_y;
			time_s1        <= time_ms;
		end
	end

	// Displacement from the begin point and the movement threshold test.
	assign dx  = {pos_x_s1[15], pos_x_s1} - {start_x_q[15], start_x_q};
	assign dy  = {pos_y_s1[15], pos_y_s1} - {start_y_q[15], start_y_q};
	assign adx = dx[16] ? (17'd0 - dx) : dx;
	assign ady = dy[16] ? (17'd0 - dy) : dy;
	assign ovx = adx > {1'b0, cfg.min_move};
	assign ovy = ady > {1'b0, cfg.min_move};

	always_comb begin
		phase_d           = phase_q;
		load              = 1'b0;
		go_idle           = 1'b0;
		item_d.ev         = EV_FAILED;
		item_d.has_result = 1'b0;
		item_d.judge      = 1'b0;
		item_d.ovx        = ovx;
		item_d.ovy        = ovy;
		item_d.dx         = dx;
		item_d.dy         = dy;
		item_d.dt         = time_s1 - start_time_q;
		unique case (func_s1)
			FUNC_BEGAN: begin
				if (phase_q == PH_IDLE && touch_valid_s1) begin
					load              = 1'b1;
					phase_d           = PH_BEGUN;
					item_d.has_result = 1'b1;
					item_d.ev         = EV_BEGIN;
					item_d.dx         = '0;
					item_d.dy         = '0;
				end
			end
			FUNC_MOVED: begin
				if (phase_q == PH_BEGUN) begin
					if ((cfg.allow_h && ovx) || (cfg.allow_v && ovy)) begin
						phase_d           = PH_MOVING;
						item_d.has_result = 1'b1;
						item_d.ev         = EV_MOVED;
					end
				end else if (phase_q == PH_MOVING) begin
					item_d.has_result = 1'b1;
					item_d.ev         = EV_MOVED;
				end
			end
			FUNC_ENDED: begin
				// Only a swipe that got to the moving phase is judged for success.
				item_d.has_result = 1'b1;
				item_d.judge      = (phase_q == PH_MOVING);
				go_idle           = 1'b1;
			end
			FUNC_CANCEL: begin
				go_idle = 1'b1;
			end
			default: begin
			end
		endcase
		if (go_idle) begin
			phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			start_x_q    <= '0;
			start_y_q    <= '0;
			start_time_q <= '0;
		end else if (s1_fire) begin
			phase_q <= phase_d;
			if (load) begin
				start_x_q    <= pos_x_s1;
				start_y_q    <= pos_y_s1;
				start_time_q <= time_s1;
			end else if (go_idle) begin
				start_x_q    <= '0;
				start_y_q    <= '0;
				start_time_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			item_s2 <= item_d;
		end
	end

	assign item_valid = v_s2;
	assign item       = item_s2;

	`SWD_ASSERT_NEXT(a_cancel_idles, s1_fire && func_s1 == FUNC_CANCEL, phase_q == PH_IDLE, "cancel did not return to idle")
	`SWD_ASSERT(a_idle_cleared, (phase_q != PH_IDLE) || (start_x_q == 16'd0 && start_y_q == 16'd0 && start_time_q == 32'd0), "idle phase with a stale begin point")
	`SWD_ASSERT_NEXT(a_s2_holds, v_s2 && !item_ready, v_s2 && $stable(item_s2), "stalled stage two word changed")

endmodule

`default_nettype wire

// ===== rtl/core/swd_judge.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "swipe_gesture_detector_unit_assert.svh"

module swd_judge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swd_pkg::swd_cfg_t    cfg,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  swd_pkg::swd_item_t   item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           gesture_event,
	output logic                 success_horizontal,
	output logic                 success_vertical,
	output logic signed [16:0]   total_dx,
	output logic signed [16:0]   total_dy
);
	import swd_pkg::*;

	logic        out_valid_q;
	logic [1:0]  ev_q;
	logic        h_q;
	logic        v_q;
	logic [16:0] dx_q;
	logic [16:0] dy_q;

	logic [47:0] prod;
	logic        dt_zero;
	logic        vel_x;
	logic        vel_y;
	logic        ok_h;
	logic        ok_v;
	logic [1:0]  ev_d;

	// Velocity test d * 256 > min_velocity * dt; only a positive d can pass.
	assign prod    = {32'd0, cfg.min_vel} * {16'd0, item.dt};
	assign dt_zero = (item.dt == 32'd0);
	assign vel_x   = !item.dx[16] && ({24'd0, item.dx[15:0], 8'd0} > prod);
	assign vel_y   = !item.dy[16] && ({24'd0, item.dy[15:0], 8'd0} > prod);
	assign ok_h    = item.judge && cfg.allow_h && (item.ovx || dt_zero || vel_x);
	assign ok_v    = item.judge && cfg.allow_v && (item.ovy || dt_zero || vel_y);

	always_comb begin
		ev_d = item.ev;
		if (item.judge) begin
			ev_d = (ok_h || ok_v) ? EV_SUCCESS : EV_FAILED;
		end
	end

	assign item_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_ready) begin
			out_valid_q <= item_valid && item.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready && item.has_result) begin
			ev_q <= ev_d;
			h_q  <= ok_h;
			v_q  <= ok_v;
			dx_q <= item.dx;
			dy_q <= item.dy;
		end
	end

	assign out_valid          = out_valid_q;
	assign gesture_event      = ev_q;
	assign success_horizontal = h_q;
	assign success_vertical   = v_q;
	assign total_dx           = dx_q;
	assign total_dy           = dy_q;

	`SWD_ASSERT(a_success_axes, !out_valid_q || ((ev_q == EV_SUCCESS) == (h_q || v_q)), "success flags disagree with the event")
	`SWD_ASSERT(a_begin_zero, !(out_valid_q && ev_q == EV_BEGIN) || (dx_q == 17'd0 && dy_q == 17'd0), "begin event with nonzero displacement")

endmodule

`default_nettype wire

// ===== rtl/core/swipe_gesture_detector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Swipe detector. Touch events come in on the in_valid/in_ready channel, one word per
// event (func, touch_valid, pos_x, pos_y, time_ms); gesture events go out on the
// out_valid/out_ready channel. An event yields zero or one gesture word; ignored
// events (a move below the threshold, cancel, a stray begin) produce nothing.
// An accepted word is registered in stage one, then in stage two, then in the
// output register. One word is accepted every cycle unless the receiver stalls:
// stage one tracks the phase and begin point, stage two runs the velocity check
// (one 16 x 32 multiply and two compares); the output register holds the result.
// When the receiver stalls, the output register holds its word and the two
// stages behind it keep filling, so up to three words are taken before in_ready
// drops; nothing is lost or repeated.
// Reset clears the phase to idle, the begin point and time to zero, and loads the
// configuration defaults. Configuration is written through cfg_we, cfg_index and
// cfg_data and should only change while no event is in flight.
module swipe_gesture_detector_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	input  logic                 touch_valid,
	input  logic signed [15:0]   pos_x,
	input  logic signed [15:0]   pos_y,
	input  logic [31:0]          time_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           gesture_event,
	output logic                 success_horizontal,
	output logic                 success_vertical,
	output logic signed [16:0]   total_dx,
	output logic signed [16:0]   total_dy,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [swd_pkg::CFG_W-1:0] cfg_data
);
	import swd_pkg::*;

	swd_cfg_t  cfg;
	logic      item_valid;
	logic      item_ready;
	swd_item_t item;

	swd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	swd_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.touch_valid (touch_valid),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.time_ms     (time_ms),
		.cfg         (cfg),
		.item_ready  (item_ready),
		.item_valid  (item_valid),
		.item        (item)
	);

	swd_judge u_judge (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg),
		.item_valid         (item_valid),
		.item_ready         (item_ready),
		.item               (item),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.gesture_event      (gesture_event),
		.success_horizontal (success_horizontal),
		.success_vertical   (success_vertical),
		.total_dx           (total_dx),
		.total_dy           (total_dy)
	);

endmodule

`default_nettype wire
